// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds on every rising clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition on one edge implies a result on the next edge
`define ASSERT_NEXT(label, clk, rst_n, cond, res) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("assertion failed");

`else

`define ASSERT_AT(label, clk, rst_n, prop)

`define ASSERT_NEXT(label, clk, rst_n, cond, res)

`endif

`endif

// ===== hw/rtl/lopc_pkg.sv =====
package lopc_pkg;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 40;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PRIO_EXT_W = 9;

    localparam int DATE_W = 16;
    localparam int KEY_W = 31;
    localparam int PRIO_W = 3;
    localparam int OUT_COUNT_W = 32;

    // input tdata layout
    localparam int ORDER_DATE_LSB = 0;
    localparam int ORDER_KEY_LSB = ORDER_DATE_LSB + DATE_W;
    localparam int LINE_KEY_LSB = ORDER_KEY_LSB + KEY_W;
    localparam int PRIO_LSB = LINE_KEY_LSB + KEY_W;
    localparam int COMMIT_LSB = PRIO_LSB + PRIO_W;
    localparam int RECEIPT_LSB = COMMIT_LSB + DATE_W;
    localparam int S_USED_W = RECEIPT_LSB + DATE_W;

    // output tdata layout
    localparam int GROUP_LSB = 0;
    localparam int COUNT_LSB = GROUP_LSB + PRIO_W;
    localparam int M_USED_W = COUNT_LSB + OUT_COUNT_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_START = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_END = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_CHECK = 2'd2;

    localparam logic FUNC_LINE_ITEM = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef struct packed {
        logic accept;
        logic update;
        logic sel_scan;
        logic scan_start;
        logic scan_step;
        logic load_out;
        logic clear_valid;
    } cmd_t;

    typedef struct packed {
        logic item_flush;
        logic item_rmw;
        logic any_valid;
        logic cur_valid;
        logic idx_last;
        logic out_last;
    } status_t;

endpackage

// ===== hw/rtl/late_order_priority_count_unit.sv =====
// channel  | direction | tdata                                   | tuser | tlast
// s_       | in        | order_date, order_key, line_order_key,  | func  | last_in_order
//          |           | priority_req, commit_date, receipt_date |       |
// m_       | out       | group, late_orders                      | -     | last
// cfg_     | in        | window_start, window_end, key_check     | -     | -
//
// a line item is taken in the idle state; one that closes an order whose count
// already exists also passes the update state (read-modify-write of the store)
// a flush with counts scans the store in order, one empty entry a cycle, and sends
// each nonzero count via the load and send states; no input is taken meanwhile
// reset is synchronous and active low; all counts read as zero after it
// a stalled result holds m_tdata and m_tlast until the transfer
module late_order_priority_count_unit #(
    parameter int NUM_GROUPS = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lopc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lopc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // order_date, order_key, line_order_key, priority_req, commit_date, receipt_date
    input  logic [lopc_pkg::S_TDATA_W-1:0]      s_tdata,
    // func
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // group, late_orders
    output logic [lopc_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    lopc_pkg::cmd_t    cmd;
    lopc_pkg::status_t status;

    lopc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lopc_datapath #(
        .NUM_GROUPS  (NUM_GROUPS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== hw/rtl/lopc_ctrl.sv =====
`include "assert_macros.svh"

module lopc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  lopc_pkg::status_t status,
    output lopc_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_LOAD,
        ST_SEND
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_SEND);

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (status.item_flush) begin
                        if (status.any_valid) begin
                            cmd.scan_start = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end else if (status.item_rmw) begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                cmd.sel_scan = 1'b1;
                if (status.cur_valid) begin
                    state_next = ST_LOAD;
                end else if (status.idx_last) begin
                    cmd.clear_valid = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_LOAD: begin
                cmd.load_out = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_tready) begin
                    if (status.out_last) begin
                        cmd.clear_valid = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.scan_step = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_AT(a_no_input_while_output, aclk, aresetn, m_tvalid |-> !s_tready)
    `ASSERT_NEXT(a_load_shows_result, aclk, aresetn, cmd.load_out, m_tvalid)
    `ASSERT_NEXT(a_last_frees_input, aclk, aresetn, m_tvalid && m_tready && status.out_last, s_tready)

endmodule

// ===== hw/rtl/lopc_datapath.sv =====
`include "assert_macros.svh"

module lopc_datapath #(
    parameter int NUM_GROUPS = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lopc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lopc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [lopc_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    input  lopc_pkg::cmd_t                      cmd,
    output lopc_pkg::status_t                   status,
    output logic [lopc_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

    logic signed [lopc_pkg::DATE_W-1:0] window_start_reg;
    logic signed [lopc_pkg::DATE_W-1:0] window_end_reg;
    logic                               key_check_reg;

    logic signed [lopc_pkg::DATE_W-1:0] order_date;
    logic [lopc_pkg::KEY_W-1:0]         order_key;
    logic [lopc_pkg::KEY_W-1:0]         line_order_key;
    logic [lopc_pkg::PRIO_W-1:0]        priority_req;
    logic [lopc_pkg::DATE_W-1:0]        commit_date;
    logic [lopc_pkg::DATE_W-1:0]        receipt_date;

    logic [lopc_pkg::PRIO_EXT_W-1:0]    prio_ext;
    logic [GW-1:0]                      prio_idx;
    logic                               in_range;
    logic                               in_window;
    logic                               key_ok;
    logic                               late_now;
    logic                               seen_all;
    logic                               count_now;
    logic                               first_write;

    logic                               late_seen_reg;
    logic [NUM_GROUPS-1:0]              valid_reg;
    logic [NUM_GROUPS-1:0]              valid_next;
    logic [NUM_GROUPS-1:0]              above;
    logic                               later_valid;
    logic [GW-1:0]                      idx_reg;
    logic [GW-1:0]                      upd_idx_reg;
    logic [GW-1:0]                      rd_addr;

    logic [COUNT_WIDTH-1:0]             mem [NUM_GROUPS];
    logic [COUNT_WIDTH-1:0]             rd_data_reg;
    logic [COUNT_WIDTH-1:0]             inc;

    logic [lopc_pkg::PRIO_W-1:0]        group_reg;
    logic [lopc_pkg::OUT_COUNT_W-1:0]   count_out_reg;
    logic                               last_reg;

    // input field unpacking
    assign order_date = s_tdata[lopc_pkg::ORDER_DATE_LSB +: lopc_pkg::DATE_W];
    assign order_key = s_tdata[lopc_pkg::ORDER_KEY_LSB +: lopc_pkg::KEY_W];
    assign line_order_key = s_tdata[lopc_pkg::LINE_KEY_LSB +: lopc_pkg::KEY_W];
    assign priority_req = s_tdata[lopc_pkg::PRIO_LSB +: lopc_pkg::PRIO_W];
    assign commit_date = s_tdata[lopc_pkg::COMMIT_LSB +: lopc_pkg::DATE_W];
    assign receipt_date = s_tdata[lopc_pkg::RECEIPT_LSB +: lopc_pkg::DATE_W];

    assign prio_ext = lopc_pkg::PRIO_EXT_W'(priority_req);
    assign prio_idx = GW'(prio_ext);
    assign in_range = prio_ext < lopc_pkg::PRIO_EXT_W'(NUM_GROUPS);
    assign in_window = (order_date >= window_start_reg) && (order_date < window_end_reg);
    assign key_ok = !key_check_reg || (order_key == line_order_key);
    assign late_now = in_window && key_ok && (commit_date < receipt_date);
    assign seen_all = late_seen_reg || late_now;
    assign count_now = s_tlast && seen_all && in_range;
    assign first_write = cmd.accept && (s_tuser == lopc_pkg::FUNC_LINE_ITEM)
                         && count_now && !valid_reg[prio_idx];

    assign inc = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + COUNT_WIDTH'(1);
    assign rd_addr = cmd.sel_scan ? idx_reg : prio_idx;

    // entries above the scan index that still hold a count
    always_comb begin
        for (int i = 0; i < NUM_GROUPS; i++) begin
            above[i] = GW'(i) > idx_reg;
        end
    end
    assign later_valid = |(valid_reg & above);

    always_comb begin
        valid_next = valid_reg;
        if (cmd.clear_valid) begin
            valid_next = '0;
        end else if (first_write) begin
            valid_next[prio_idx] = 1'b1;
        end
    end

    always_comb begin
        status.item_flush = (s_tuser == lopc_pkg::FUNC_FLUSH);
        status.item_rmw = (s_tuser == lopc_pkg::FUNC_LINE_ITEM) && count_now
                          && valid_reg[prio_idx];
        status.any_valid = |valid_reg;
        status.cur_valid = valid_reg[idx_reg];
        status.idx_last = (idx_reg == GW'(NUM_GROUPS - 1));
        status.out_last = last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_start_reg <= '0;
            window_end_reg <= '0;
            key_check_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lopc_pkg::CFG_WINDOW_START: window_start_reg <= cfg_wdata;
                lopc_pkg::CFG_WINDOW_END: window_end_reg <= cfg_wdata;
                lopc_pkg::CFG_KEY_CHECK: key_check_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            late_seen_reg <= 1'b0;
            valid_reg <= '0;
            idx_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            if (cmd.accept && (s_tuser == lopc_pkg::FUNC_LINE_ITEM)) begin
                late_seen_reg <= s_tlast ? 1'b0 : seen_all;
            end
            if (cmd.scan_start) begin
                idx_reg <= '0;
            end else if (cmd.scan_step) begin
                idx_reg <= idx_reg + GW'(1);
            end
        end
    end

    // count store, one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (first_write) begin
            mem[prio_idx] <= COUNT_WIDTH'(1);
        end else if (cmd.update) begin
            mem[upd_idx_reg] <= inc;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            upd_idx_reg <= prio_idx;
        end
        if (cmd.load_out) begin
            group_reg <= lopc_pkg::PRIO_W'(lopc_pkg::PRIO_EXT_W'(idx_reg));
            count_out_reg <= lopc_pkg::OUT_COUNT_W'(rd_data_reg);
            last_reg <= !later_valid;
        end
    end

    assign m_tdata = {(lopc_pkg::M_TDATA_W - lopc_pkg::M_USED_W)'(0), count_out_reg, group_reg};
    assign m_tlast = last_reg;

    `ASSERT_NEXT(a_flush_clears, aclk, aresetn, cmd.clear_valid, valid_reg == '0)
    `ASSERT_NEXT(a_first_write_marks, aclk, aresetn, first_write, status.any_valid)

endmodule

// ===== bench/late_order_priority_count_checker.sv =====
module late_order_priority_count_checker #(
    parameter int NUM_GROUPS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lopc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lopc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [lopc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tuser,
    input  logic                             s_tlast,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [lopc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             m_tlast,
    output int                               fail_count,
    output int                               pending,
    output int                               results_seen
);

    localparam int S_TDATA_W = lopc_pkg::S_TDATA_W;
    localparam int DATE_W = lopc_pkg::DATE_W;
    localparam int KEY_W = lopc_pkg::KEY_W;
    localparam int PRIO_W = lopc_pkg::PRIO_W;
    localparam int OUT_COUNT_W = lopc_pkg::OUT_COUNT_W;
    localparam int GROUP_LSB = lopc_pkg::GROUP_LSB;
    localparam int COUNT_LSB = lopc_pkg::COUNT_LSB;

    typedef struct packed {
        logic [PRIO_W-1:0]      group;
        logic [OUT_COUNT_W-1:0] late_orders;
        logic                   last;
    } count_report_t;

    count_report_t count_reports_q[$];

    logic [OUT_COUNT_W-1:0]        prio_count[NUM_GROUPS];
    logic                          late_flag;
    logic signed [DATE_W-1:0]      win_lo;
    logic signed [DATE_W-1:0]      win_hi;
    logic                          key_match_on;
    int                            fails = 0;
    int                            got = 0;

    task automatic predict_counts(input logic [S_TDATA_W-1:0] d, input logic flush,
                                  input logic closes);
        logic signed [DATE_W-1:0] odate;
        logic [KEY_W-1:0]         okey;
        logic [KEY_W-1:0]         lkey;
        logic [PRIO_W-1:0]        prio;
        logic [DATE_W-1:0]        commit;
        logic [DATE_W-1:0]        receipt;
        int                       top_g;
        count_report_t            rep;
        if (flush) begin
            top_g = -1;
            for (int g = 0; g < NUM_GROUPS; g++) begin
                if (prio_count[g] != '0) top_g = g;
            end
            for (int g = 0; g < NUM_GROUPS; g++) begin
                if (prio_count[g] != '0) begin
                    rep.group = PRIO_W'(g);
                    rep.late_orders = prio_count[g];
                    rep.last = (g == top_g);
                    count_reports_q.insert(count_reports_q.size(), rep);
                end
                prio_count[g] = '0;
            end
        end else begin
            odate = d[lopc_pkg::ORDER_DATE_LSB +: DATE_W];
            okey = d[lopc_pkg::ORDER_KEY_LSB +: KEY_W];
            lkey = d[lopc_pkg::LINE_KEY_LSB +: KEY_W];
            prio = d[lopc_pkg::PRIO_LSB +: PRIO_W];
            commit = d[lopc_pkg::COMMIT_LSB +: DATE_W];
            receipt = d[lopc_pkg::RECEIPT_LSB +: DATE_W];
            if (odate >= win_lo && odate < win_hi && (!key_match_on || okey == lkey)
                && commit < receipt)
                late_flag = 1'b1;
            if (closes) begin
                if (late_flag && int'(prio) < NUM_GROUPS && prio_count[prio] != '1)
                    prio_count[prio] = prio_count[prio] + 1'b1;
                late_flag = 1'b0;
            end
        end
    endtask

    always @(posedge aclk) begin
        count_report_t exp_rep;
        if (!aresetn) begin
            for (int g = 0; g < NUM_GROUPS; g++) prio_count[g] = '0;
            late_flag = 1'b0;
            win_lo = '0;
            win_hi = '0;
            key_match_on = 1'b1;
            count_reports_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got++;
                if (count_reports_q.size() == 0) begin
                    $error("unexpected result: group %0d, late_orders %0d, last %0d",
                           m_tdata[GROUP_LSB +: PRIO_W], m_tdata[COUNT_LSB +: OUT_COUNT_W],
                           m_tlast);
                    fails++;
                end else begin
                    exp_rep = count_reports_q.pop_front();
                    if (m_tdata[GROUP_LSB +: PRIO_W] !== exp_rep.group) begin
                        $error("group mismatch: expected %0d, actual %0d", exp_rep.group,
                               m_tdata[GROUP_LSB +: PRIO_W]);
                        fails++;
                    end
                    if (m_tdata[COUNT_LSB +: OUT_COUNT_W] !== exp_rep.late_orders) begin
                        $error("late_orders mismatch: expected %0d, actual %0d",
                               exp_rep.late_orders, m_tdata[COUNT_LSB +: OUT_COUNT_W]);
                        fails++;
                    end
                    if (m_tlast !== exp_rep.last) begin
                        $error("last mismatch: expected %0d, actual %0d", exp_rep.last,
                               m_tlast);
                        fails++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    lopc_pkg::CFG_WINDOW_START: win_lo = cfg_wdata[DATE_W-1:0];
                    lopc_pkg::CFG_WINDOW_END: win_hi = cfg_wdata[DATE_W-1:0];
                    lopc_pkg::CFG_KEY_CHECK: key_match_on = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_counts(s_tdata, s_tuser == lopc_pkg::FUNC_FLUSH, s_tlast);
        end
        fail_count <= fails;
        results_seen <= got;
        pending <= count_reports_q.size();
    end

endmodule

// ===== bench/late_order_priority_count_unit_tb.sv =====
module late_order_priority_count_unit_tb;

    localparam int CFG_INDEX_W = lopc_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W = lopc_pkg::CFG_DATA_W;
    localparam int S_TDATA_W = lopc_pkg::S_TDATA_W;
    localparam int M_TDATA_W = lopc_pkg::M_TDATA_W;
    localparam int DATE_W = lopc_pkg::DATE_W;
    localparam int KEY_W = lopc_pkg::KEY_W;
    localparam int PRIO_W = lopc_pkg::PRIO_W;

    localparam int LIMIT = 200000;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    int fail_count;
    int pending;
    int results_seen;
    int tx_pct = 0;
    int rx_pct = 0;
    logic hold_req = 1'b0;
    int hold_left = 0;
    int sent = 0;
    int cur_ws = 0;
    int cur_we = 0;
    int cycle_n = 0;

    late_order_priority_count_unit #(
        .NUM_GROUPS(8),
        .COUNT_WIDTH(32)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    late_order_priority_count_checker #(
        .NUM_GROUPS(8)
    ) chk (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .fail_count(fail_count),
        .pending(pending),
        .results_seen(results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic bit coin(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left <= 150;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !coin(rx_pct);
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_line(
        input logic [DATE_W-1:0] date, input logic [KEY_W-1:0] okey,
        input logic [KEY_W-1:0] lkey, input logic [PRIO_W-1:0] prio,
        input logic [DATE_W-1:0] commit, input logic [DATE_W-1:0] receipt);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[lopc_pkg::ORDER_DATE_LSB +: DATE_W] = date;
        d[lopc_pkg::ORDER_KEY_LSB +: KEY_W] = okey;
        d[lopc_pkg::LINE_KEY_LSB +: KEY_W] = lkey;
        d[lopc_pkg::PRIO_LSB +: PRIO_W] = prio;
        d[lopc_pkg::COMMIT_LSB +: DATE_W] = commit;
        d[lopc_pkg::RECEIPT_LSB +: DATE_W] = receipt;
        return d;
    endfunction

    function automatic logic [S_TDATA_W-1:0] rand_fields();
        return pack_line(DATE_W'($urandom), KEY_W'($urandom), KEY_W'($urandom),
                         PRIO_W'($urandom), DATE_W'($urandom), DATE_W'($urandom));
    endfunction

    function automatic logic [DATE_W-1:0] pick_date();
        case ($urandom_range(0, 5))
            0: return DATE_W'(cur_ws);
            1: return DATE_W'(cur_we - 1);
            2: return DATE_W'(cur_we);
            3: return DATE_W'(cur_ws - 1);
            default: begin
                if (cur_ws < cur_we)
                    return DATE_W'(cur_ws + int'($urandom_range(0, cur_we - cur_ws - 1)));
                else
                    return DATE_W'($urandom);
            end
        endcase
    endfunction

    task automatic send(input logic func, input logic [S_TDATA_W-1:0] data,
                        input logic last);
        while (coin(tx_pct)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= data;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic send_line(input logic [DATE_W-1:0] date, input logic [KEY_W-1:0] okey,
                             input logic [KEY_W-1:0] lkey, input logic [PRIO_W-1:0] prio,
                             input logic [DATE_W-1:0] commit,
                             input logic [DATE_W-1:0] receipt, input logic last);
        send(lopc_pkg::FUNC_LINE_ITEM, pack_line(date, okey, lkey, prio, commit, receipt),
             last);
    endtask

    task automatic send_flush();
        send(lopc_pkg::FUNC_FLUSH, rand_fields(), coin(50));
    endtask

    // one order: shared date, key and priority, last marker on the final line item
    task automatic send_order();
        int n;
        logic [DATE_W-1:0] date;
        logic [KEY_W-1:0]  okey;
        logic [PRIO_W-1:0] prio;
        logic [DATE_W-1:0] commit;
        n = $urandom_range(1, 4);
        date = pick_date();
        okey = KEY_W'($urandom);
        prio = PRIO_W'($urandom_range(0, 7));
        for (int i = 0; i < n; i++) begin
            commit = DATE_W'($urandom);
            send_line(date, okey, coin(85) ? okey : KEY_W'($urandom), prio, commit,
                      coin(60) ? DATE_W'($urandom) : (coin(50) ? commit : commit + 1'b1),
                      i == n - 1);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (48) @(posedge aclk);
    endtask

    task automatic set_filter(input int ws, input int we, input logic kc,
                              input logic stray);
        cfg_wr_en <= 1'b1;
        if (stray) begin
            cfg_index <= CFG_UNUSED;
            cfg_wdata <= '1;
            @(posedge aclk);
        end
        cfg_index <= lopc_pkg::CFG_WINDOW_START;
        cfg_wdata <= CFG_DATA_W'(ws);
        @(posedge aclk);
        cfg_index <= lopc_pkg::CFG_WINDOW_END;
        cfg_wdata <= CFG_DATA_W'(we);
        @(posedge aclk);
        cfg_index <= lopc_pkg::CFG_KEY_CHECK;
        cfg_wdata <= {15'($urandom), kc};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_ws = ws;
        cur_we = we;
    endtask

    initial begin
        int phase;
        int start;
        int r;
        bit paused;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_filter(-32768, 32767, 1'b1, 1'b1);
        // flush with nothing counted
        send_flush();
        send_line(16'h8000, '0, '0, 3'd0, 16'h0000, 16'hFFFF, 1'b1);
        send_line(16'h7FFE, KEY_MAX, KEY_MAX, 3'd7, 16'hFFFF, 16'hFFFF, 1'b0);
        send_line(16'h7FFE, KEY_MAX, KEY_MAX, 3'd7, 16'hFFFE, 16'hFFFF, 1'b1);
        // key mismatch, then date on the exclusive window end
        send_line(16'd10, 31'd5, 31'd6, 3'd3, 16'd0, 16'd9, 1'b1);
        send_line(16'h7FFF, 31'd9, 31'd9, 3'd2, 16'd0, 16'd9, 1'b1);
        // flush in the middle of a late order
        send_line(16'd20, 31'd11, 31'd11, 3'd4, 16'd1, 16'd2, 1'b0);
        send_flush();
        send_line(16'd20, 31'd11, 31'd11, 3'd4, 16'd5, 16'd5, 1'b1);
        // unsigned date compare
        send_line(16'd0, 31'd12, 31'd12, 3'd1, 16'h8000, 16'h7FFF, 1'b1);
        send_line(16'd0, 31'd13, 31'd13, 3'd1, 16'h7FFF, 16'h8000, 1'b1);
        send_line(16'd0, 31'd14, 31'd14, 3'd5, 16'd3, 16'd3, 1'b0);
        send_line(16'd0, 31'd14, 31'd14, 3'd5, 16'd4, 16'd3, 1'b1);
        send_line(16'd0, 31'd15, 31'd15, 3'd1, 16'd0, 16'd1, 1'b1);
        send_line(16'd0, 31'd16, 31'd17, 3'd6, 16'd0, 16'd1, 1'b0);
        send_line(16'd0, 31'd16, 31'd16, 3'd6, 16'd2, 16'd1, 1'b1);
        send_flush();
        send_flush();
        settle();
        set_filter(-32768, 32767, 1'b0, 1'b0);
        send_line(16'd0, 31'd5, 31'd6, 3'd3, 16'd0, 16'd9, 1'b1);
        send_line(16'h8000, KEY_MAX, '0, 3'd7, 16'd0, 16'd1, 1'b1);
        send_flush();
        settle();

        sent = 0;
        for (phase = 0; sent < 230 || results_seen < 48; phase++) begin
            case (phase)
                0: set_filter(-32768, 32767, 1'b1, 1'b0);
                1: set_filter(-100, 100, 1'b0, 1'b0);
                2: set_filter(500, 500, 1'b1, 1'b0);
                3: set_filter(32767, -32768, 1'b0, 1'b0);
                4: set_filter(-1000, 1000, 1'b1, 1'b0);
                5: set_filter(-32768, -32767, 1'b0, 1'b0);
                6: set_filter(32766, 32767, 1'b1, 1'b0);
                7: set_filter(int'($urandom_range(0, 65535)) - 32768,
                              int'($urandom_range(0, 65535)) - 32768, 1'(coin(50)), 1'b0);
                default: set_filter(-32768, 32767, 1'(coin(50)), 1'b0);
            endcase
            case (phase % 4)
                0: begin tx_pct = 0; rx_pct = 0; end
                1: begin tx_pct = 47; rx_pct = 0; end
                2: begin tx_pct = 0; rx_pct = 47; end
                default: begin tx_pct = 11; rx_pct = 11; end
            endcase
            if (phase == 4) begin
                // long receiver hold-off while late orders and a flush keep coming
                hold_req <= 1'b1;
                @(posedge aclk);
                hold_req <= 1'b0;
                for (int p = 0; p < 6; p++)
                    send_line(16'd0, 31'(p + 40), 31'(p + 40), 3'(p), 16'd0, 16'd1, 1'b1);
                send_flush();
            end
            start = sent;
            paused = 1'b0;
            while (sent - start < 30) begin
                if (!paused && sent - start >= 15) begin
                    send_flush();
                    settle();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 8)
                    send_flush();
                else if (r < 18)
                    send(coin(20) ? lopc_pkg::FUNC_FLUSH : lopc_pkg::FUNC_LINE_ITEM,
                         rand_fields(), coin(50));
                else
                    send_order();
            end
            send_flush();
            settle();
        end

        tx_pct = 0;
        rx_pct = 0;
        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== late_order_priority_count_unit.f =====
+incdir+hw/rtl
hw/rtl/lopc_pkg.sv
hw/rtl/lopc_ctrl.sv
hw/rtl/lopc_datapath.sv
hw/rtl/late_order_priority_count_unit.sv
bench/late_order_priority_count_checker.sv
bench/late_order_priority_count_unit_tb.sv
